// File: hw/rtl/iekmd_pkg.sv
// types and constants of the input event key and motion decoder
`default_nettype none

package iekmd_pkg;

   localparam int unsigned KIND_W  = 5;
   localparam int unsigned CODE_W  = 10;
   localparam int unsigned VALUE_W = 32;
   localparam int unsigned ACTION_W = 2;

   // key map rows hold eight keys each
   localparam int unsigned BIT_W    = 3;
   localparam int unsigned ROW_KEYS = 8;

   localparam logic [KIND_W-1:0] EV_SYN = 5'd0;
   localparam logic [KIND_W-1:0] EV_KEY = 5'd1;
   localparam logic [KIND_W-1:0] EV_REL = 5'd2;

   localparam logic [CODE_W-1:0] SYNC_FLUSH = 10'd0;
   localparam logic [CODE_W-1:0] REL_X      = 10'd0;
   localparam logic [CODE_W-1:0] REL_Y      = 10'd1;

   localparam logic RESULT_KEY    = 1'b0;
   localparam logic RESULT_MOTION = 1'b1;

   localparam logic [ACTION_W-1:0] KEY_RELEASE = 2'd0;
   localparam logic [ACTION_W-1:0] KEY_PRESS   = 2'd1;
   localparam logic [ACTION_W-1:0] KEY_REPEAT  = 2'd2;

   typedef struct packed {
      logic                       from_mouse;
      logic [KIND_W-1:0]          event_kind;
      logic [CODE_W-1:0]          event_code;
      logic signed [VALUE_W-1:0]  event_value;
   } req_type;

   typedef struct packed {
      logic                       result_kind;
      logic                       source_is_mouse;
      logic [CODE_W-1:0]          key_number;
      logic [ACTION_W-1:0]        key_action;
      logic signed [VALUE_W-1:0]  motion_x;
      logic signed [VALUE_W-1:0]  motion_y;
   } rsp_type;

endpackage

`default_nettype wire

// File: hw/rtl/input_event_key_and_motion_decoder.sv
// top level of the input event key and motion decoder
//
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall | iekmd_pkg::req_type
//  rsp     | out       | rsp_valid/rsp_stall | iekmd_pkg::rsp_type
//
// one transaction per cycle unless a result stalls; results pass stage one and rsp_ff
// the key map row is read at accept and written back at retire, with forwarding
// the held-key map lives in a memory of eight-key rows; per-row valid bits clear on reset
// reset is synchronous and active high; no clearing pass is needed
// a stalled result holds in the output register while the next transaction waits in stage one
`default_nettype none

module input_event_key_and_motion_decoder #(
   parameter int unsigned NUM_KEYS = 768
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  iekmd_pkg::req_type  req_payload,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output iekmd_pkg::rsp_type  rsp_payload
);
   import iekmd_pkg::*;

   localparam int unsigned ROWS  = (NUM_KEYS + ROW_KEYS - 1) / ROW_KEYS;
   localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

   function automatic logic signed [VALUE_W-1:0] sat_add(
      input logic signed [VALUE_W-1:0] a,
      input logic signed [VALUE_W-1:0] b
   );
      logic signed [VALUE_W:0] s;
      s = {a[VALUE_W-1], a} + {b[VALUE_W-1], b};
      if (s[VALUE_W] != s[VALUE_W-1]) begin
         sat_add = s[VALUE_W] ? {1'b1, {(VALUE_W-1){1'b0}}} : {1'b0, {(VALUE_W-1){1'b1}}};
      end else begin
         sat_add = s[VALUE_W-1:0];
      end
   endfunction

   logic [ROW_KEYS-1:0] key_mem [ROWS];
   logic [ROW_KEYS-1:0] rd_ff;
   logic [ROWS-1:0]     row_valid_ff, row_valid_in;

   logic                s1_valid_ff, s1_valid_in;
   req_type             s1_ff;

   logic                fwd_valid_ff, fwd_valid_in;
   logic [ROW_W-1:0]    fwd_row_ff;
   logic [ROW_KEYS-1:0] fwd_data_ff;

   logic signed [VALUE_W-1:0] sum_x_ff, sum_x_in, sum_y_ff, sum_y_in;

   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic                accept, retire, out_free, has_result;
   logic                req_in_map, s1_in_map, is_key, is_report, pressed, held;
   logic [ROW_W-1:0]    req_row, s1_row;
   logic [BIT_W-1:0]    s1_bit;
   logic [ROW_KEYS-1:0] eff_row, new_row;
   logic [ACTION_W-1:0] action;
   logic                wr_en;

   assign req_in_map = {1'b0, req_payload.event_code} < (CODE_W + 1)'(NUM_KEYS);
   assign req_row    = req_in_map ? ROW_W'(req_payload.event_code[CODE_W-1:BIT_W]) : '0;

   assign s1_in_map = {1'b0, s1_ff.event_code} < (CODE_W + 1)'(NUM_KEYS);
   assign s1_row    = s1_in_map ? ROW_W'(s1_ff.event_code[CODE_W-1:BIT_W]) : '0;
   assign s1_bit    = s1_ff.event_code[BIT_W-1:0];

   assign is_key    = (s1_ff.event_kind == EV_KEY);
   assign is_report = s1_ff.from_mouse && (s1_ff.event_kind == EV_SYN)
                      && (s1_ff.event_code == SYNC_FLUSH);
   assign has_result = is_key || is_report;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign retire    = s1_valid_ff && (!has_result || out_free);
   assign req_stall = s1_valid_ff && !retire;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      eff_row = row_valid_ff[s1_row] ? rd_ff : '0;
      if (fwd_valid_ff && (fwd_row_ff == s1_row)) begin
         eff_row = fwd_data_ff;
      end
      pressed = (s1_ff.event_value != '0);
      held    = s1_in_map && eff_row[s1_bit];
      new_row = eff_row;
      if (!pressed) begin
         action          = KEY_RELEASE;
         new_row[s1_bit] = 1'b0;
      end else if (held) begin
         action = KEY_REPEAT;
      end else begin
         action          = KEY_PRESS;
         new_row[s1_bit] = 1'b1;
      end
   end

   assign wr_en = retire && is_key && s1_in_map;

   always_comb begin
      s1_valid_in  = accept ? 1'b1 : (retire ? 1'b0 : s1_valid_ff);
      row_valid_in = row_valid_ff;
      fwd_valid_in = fwd_valid_ff;
      if (wr_en) begin
         row_valid_in[s1_row] = 1'b1;
         fwd_valid_in         = 1'b1;
      end

      sum_x_in = sum_x_ff;
      sum_y_in = sum_y_ff;
      if (retire && s1_ff.from_mouse && (s1_ff.event_kind == EV_REL)) begin
         if (s1_ff.event_code == REL_X) begin
            sum_x_in = sat_add(sum_x_ff, s1_ff.event_value);
         end else if (s1_ff.event_code == REL_Y) begin
            sum_y_in = sat_add(sum_y_ff, s1_ff.event_value);
         end
      end else if (retire && is_report) begin
         sum_x_in = '0;
         sum_y_in = '0;
      end

      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (retire && has_result) begin
         rsp_valid_in = 1'b1;
         if (is_key) begin
            rsp_in.result_kind     = RESULT_KEY;
            rsp_in.source_is_mouse = s1_ff.from_mouse;
            rsp_in.key_number      = s1_ff.event_code;
            rsp_in.key_action      = action;
            rsp_in.motion_x        = '0;
            rsp_in.motion_y        = '0;
         end else begin
            rsp_in.result_kind     = RESULT_MOTION;
            rsp_in.source_is_mouse = 1'b1;
            rsp_in.key_number      = '0;
            rsp_in.key_action      = KEY_RELEASE;
            rsp_in.motion_x        = sum_x_ff;
            rsp_in.motion_y        = sum_y_ff;
         end
      end
   end

   // key map memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[s1_row] <= new_row;
      end
      if (accept) begin
         rd_ff <= key_mem[req_row];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= req_payload;
      end
      if (wr_en) begin
         fwd_row_ff  <= s1_row;
         fwd_data_ff <= new_row;
      end
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         row_valid_ff <= '0;
         fwd_valid_ff <= 1'b0;
         sum_x_ff     <= '0;
         sum_y_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         row_valid_ff <= row_valid_in;
         fwd_valid_ff <= fwd_valid_in;
         sum_x_ff     <= sum_x_in;
         sum_y_ff     <= sum_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_stall_needs_stage : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && has_result && rsp_valid_ff))
      else $error("input stalled without a blocked result");

   a_accept_fills_stage : assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted transaction did not reach stage one");

   a_motion_clean : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.result_kind == RESULT_MOTION))
      |-> (rsp_ff.key_number == '0 && rsp_ff.source_is_mouse))
      else $error("motion packet carries key fields");

   a_action_code : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.key_action != 2'd3))
      else $error("undefined key action");

   a_report_clears : assert property (@(posedge clock) disable iff (reset)
      (retire && is_report) |=> (sum_x_ff == '0 && sum_y_ff == '0))
      else $error("motion sums not cleared after report");

endmodule

`default_nettype wire

// File: sim/input_event_key_and_motion_decoder_tb.sv
// testbench for the input event key and motion decoder: random and directed events, scoreboard
`timescale 1ns / 1ps

import iekmd_pkg::*;

class event_decode_scoreboard;
   bit      key_held [0:1023];
   longint  sum_x;
   longint  sum_y;
   int      key_slots;
   int      failures;
   rsp_type expected_results [$];

   function new(int slots);
      key_slots = slots;
      sum_x     = 0;
      sum_y     = 0;
      failures  = 0;
   endfunction

   function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function void note_event(req_type ev);
      rsp_type r;
      longint  amount;
      bit      in_map;
      r      = '0;
      amount = longint'($signed(ev.event_value));
      in_map = int'(ev.event_code) < key_slots;
      if (ev.event_kind == EV_KEY) begin
         r.result_kind     = RESULT_KEY;
         r.source_is_mouse = ev.from_mouse;
         r.key_number      = ev.event_code;
         if (ev.event_value == 0) begin
            r.key_action = KEY_RELEASE;
            if (in_map) key_held[ev.event_code] = 1'b0;
         end else if (in_map && key_held[ev.event_code]) begin
            r.key_action = KEY_REPEAT;
         end else begin
            r.key_action = KEY_PRESS;
            if (in_map) key_held[ev.event_code] = 1'b1;
         end
         expected_results.push_back(r);
      end else if (ev.from_mouse) begin
         if (ev.event_kind == EV_REL && ev.event_code == REL_X) begin
            sum_x = clamp32(sum_x + amount);
         end else if (ev.event_kind == EV_REL && ev.event_code == REL_Y) begin
            sum_y = clamp32(sum_y + amount);
         end else if (ev.event_kind == EV_SYN && ev.event_code == SYNC_FLUSH) begin
            r.result_kind     = RESULT_MOTION;
            r.source_is_mouse = 1'b1;
            r.motion_x        = sum_x[31:0];
            r.motion_y        = sum_y[31:0];
            sum_x             = 0;
            sum_y             = 0;
            expected_results.push_back(r);
         end
      end
   endfunction

   function void check_result(rsp_type got);
      rsp_type exp;
      if (expected_results.size() == 0) begin
         if (failures < 10)
            $display("unexpected result: kind %0d src %0d key %0d action %0d x %0d y %0d",
                     got.result_kind, got.source_is_mouse, got.key_number, got.key_action,
                     got.motion_x, got.motion_y);
         failures++;
         return;
      end
      exp = expected_results.pop_front();
      if (got.result_kind !== exp.result_kind || got.source_is_mouse !== exp.source_is_mouse ||
          got.key_number !== exp.key_number || got.key_action !== exp.key_action ||
          got.motion_x !== exp.motion_x || got.motion_y !== exp.motion_y) begin
         if (failures < 10) begin
            $display("mismatch: expected kind %0d src %0d key %0d action %0d x %0d y %0d",
                     exp.result_kind, exp.source_is_mouse, exp.key_number, exp.key_action,
                     exp.motion_x, exp.motion_y);
            $display("          actual   kind %0d src %0d key %0d action %0d x %0d y %0d",
                     got.result_kind, got.source_is_mouse, got.key_number, got.key_action,
                     got.motion_x, got.motion_y);
         end
         failures++;
      end
   endfunction
endclass

module input_event_key_and_motion_decoder_tb;

   localparam int KEY_SLOTS       = 768;
   localparam int QUIET_LIMIT     = 1000;
   localparam int HOLD_OFF_CYCLES = 60;
   localparam int PHASE_EVENTS    = 267;
   localparam logic [KIND_W-1:0] UNKNOWN_KIND = 5'd31;
   localparam logic [CODE_W-1:0] AXIS_WHEEL   = 10'd8;
   localparam logic [CODE_W-1:0] SYN_OTHER    = 10'd3;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall   = 1'b0;
   rsp_type rsp_payload;

   int send_idle_pct    = 12;
   int recv_idle_pct    = 66;
   bit hold_off_request = 1'b0;

   event_decode_scoreboard sb = new(KEY_SLOTS);

   input_event_key_and_motion_decoder #(.NUM_KEYS(KEY_SLOTS)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #5 clock = ~clock;

   // called at a falling edge, returns at a falling edge
   task automatic send_event(input req_type ev);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= ev;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_event(ev);
      @(negedge clock);
   endtask

   task automatic post_event(input logic mouse, input logic [KIND_W-1:0] kind,
                             input logic [CODE_W-1:0] code, input logic [VALUE_W-1:0] value);
      req_type ev;
      ev.from_mouse  = mouse;
      ev.event_kind  = kind;
      ev.event_code  = code;
      ev.event_value = value;
      send_event(ev);
   endtask

   function automatic req_type random_event();
      req_type ev;
      int      pick;
      int      spread;
      pick           = $urandom_range(99);
      ev.from_mouse  = 1'($urandom_range(1));
      ev.event_kind  = KIND_W'($urandom_range(31));
      ev.event_code  = CODE_W'($urandom_range(1023));
      ev.event_value = $urandom;
      if (pick < 35) begin
         ev.event_kind = EV_KEY;
         spread        = $urandom_range(9);
         if (spread < 7) ev.event_code = CODE_W'($urandom_range(15));
         else if (spread < 9) ev.event_code = CODE_W'($urandom_range(767));
         else ev.event_code = CODE_W'($urandom_range(1023, 768));
         if ($urandom_range(9) < 8) ev.event_value = $urandom_range(2);
      end else if (pick < 70) begin
         ev.from_mouse = 1'b1;
         ev.event_kind = EV_REL;
         ev.event_code = $urandom_range(1) ? REL_Y : REL_X;
         if ($urandom_range(4) != 0) ev.event_value = int'($urandom_range(2000)) - 1000;
      end else if (pick < 82) begin
         ev.from_mouse = 1'b1;
         ev.event_kind = EV_SYN;
         ev.event_code = SYNC_FLUSH;
      end
      return ev;
   endfunction

   // receiver side: random stall, or a long hold-off when asked
   initial begin
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES - 1) begin
               @(negedge clock);
               rsp_stall <= 1'b1;
            end
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_payload);
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("input_event_key_and_motion_decoder test failed");
      $finish;
   end

   initial begin : stimulus
      req_type ev;
      int      counted;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // key classification, shared map and codes beyond the map
      post_event(1'b0, EV_KEY, 10'd5, 32'd1);
      post_event(1'b0, EV_KEY, 10'd5, 32'd2);
      post_event(1'b0, EV_KEY, 10'd5, 32'd0);
      post_event(1'b0, EV_KEY, 10'd5, 32'd0);
      post_event(1'b1, EV_KEY, 10'd767, 32'hFFFF_FFFF);
      post_event(1'b0, EV_KEY, 10'd767, 32'd1);
      post_event(1'b0, EV_KEY, 10'd1023, 32'h7FFF_FFFF);
      post_event(1'b1, EV_KEY, 10'd1023, 32'd1);
      post_event(1'b0, EV_KEY, 10'd768, 32'd0);
      post_event(1'b0, EV_KEY, 10'd0, 32'h8000_0000);
      // saturation at both limits
      post_event(1'b1, EV_REL, REL_X, 32'h7FFF_FFFF);
      post_event(1'b1, EV_REL, REL_X, 32'd5);
      post_event(1'b1, EV_REL, REL_Y, 32'h8000_0000);
      post_event(1'b1, EV_REL, REL_Y, 32'hFFFF_FFFF);
      // ignored events, then motion reports and saturation
      post_event(1'b1, EV_REL, AXIS_WHEEL, 32'd100);
      post_event(1'b0, EV_REL, REL_X, 32'd7);
      post_event(1'b0, EV_SYN, SYNC_FLUSH, 32'd0);
      post_event(1'b1, EV_SYN, SYN_OTHER, 32'd0);
      post_event(1'b1, UNKNOWN_KIND, 10'd1023, 32'hFFFF_FFFF);
      post_event(1'b1, EV_SYN, SYNC_FLUSH, 32'd0);
      post_event(1'b1, EV_SYN, SYNC_FLUSH, 32'd0);
      post_event(1'b1, EV_REL, REL_X, 32'h8000_0000);
      post_event(1'b1, EV_REL, REL_X, 32'h8000_0000);
      post_event(1'b1, EV_REL, REL_Y, 32'h7FFF_FFFF);
      post_event(1'b1, EV_SYN, SYNC_FLUSH, 32'd0);

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct    = (phase == 0) ? 12 : (phase == 1) ? 66 : 0;
         recv_idle_pct    = (phase == 0) ? 66 : (phase == 1) ? 12 : 0;
         hold_off_request = 1'b1;
         counted          = 0;
         while (counted < PHASE_EVENTS) begin
            ev = random_event();
            send_event(ev);
            counted++;
         end
      end
      req_valid <= 1'b0;

      while (sb.expected_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.failures == 0 && sb.expected_results.size() == 0) begin
         $display("input_event_key_and_motion_decoder test passed");
      end else begin
         $display("input_event_key_and_motion_decoder test failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/iekmd_pkg.sv
hw/rtl/input_event_key_and_motion_decoder.sv
sim/input_event_key_and_motion_decoder_tb.sv
